### rtl/paa_pkg.sv
// ----------------------------------------------------------------------------
// paa_pkg
// Shared types and constants of the paragraph arena allocator.
// ----------------------------------------------------------------------------
package paa_pkg;

	// Header store geometry
	localparam int ARENA_PARAGRAPHS = 4096;
	localparam int ADDR_W           = $clog2(ARENA_PARAGRAPHS);

	// Header marks and segment limit
	localparam logic [7:0]  MARK_INNER = 8'h4d;
	localparam logic [7:0]  MARK_LAST  = 8'h5a;
	localparam logic [15:0] SEG_MAX    = 16'hffff;
	localparam logic [15:0] ARENA_END_RST = 16'd4096;

	// Operation codes
	localparam logic [3:0] OP_INIT        = 4'd0;
	localparam logic [3:0] OP_ALLOC       = 4'd1;
	localparam logic [3:0] OP_FREE        = 4'd2;
	localparam logic [3:0] OP_FREE_OWNED  = 4'd3;
	localparam logic [3:0] OP_RESIZE      = 4'd4;
	localparam logic [3:0] OP_FREE_OWNER  = 4'd5;
	localparam logic [3:0] OP_QUERY_MAX   = 4'd6;
	localparam logic [3:0] OP_TRANSFER    = 4'd7;
	localparam logic [3:0] OP_VALIDATE    = 4'd8;

	// Status codes
	localparam logic [2:0] STS_OK        = 3'd0;
	localparam logic [2:0] STS_BAD_ARG   = 3'd1;
	localparam logic [2:0] STS_BAD_BLOCK = 3'd2;
	localparam logic [2:0] STS_NO_MEM    = 3'd3;
	localparam logic [2:0] STS_MISMATCH  = 3'd4;
	localparam logic [2:0] STS_DAMAGED   = 3'd5;
	localparam logic [2:0] STS_STORE     = 3'd6;

	// Configuration register indexes
	localparam logic [1:0] CFG_FIT   = 2'd0;
	localparam logic [1:0] CFG_START = 2'd1;
	localparam logic [1:0] CFG_END   = 2'd2;

	// Fit strategies
	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_LAST  = 2'd2;

	typedef struct packed {
		logic [3:0]  operation;
		logic [15:0] block_address;
		logic [15:0] owner;
		logic [15:0] next_owner;
		logic [15:0] paragraphs;
	} paa_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] result_block;
		logic [15:0] largest_free;
	} paa_out_t;

	// Block header: mark 7:0, owner 23:8, size 39:24
	typedef struct packed {
		logic [15:0] size;
		logic [15:0] owner;
		logic [7:0]  mark;
	} hdr_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		hdr_t              wdata;
	} mem_req_t;

	typedef struct packed {
		logic idle;
		logic load;
		logic strat_clr;
	} eng_stat_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISP,
		S_INIT,
		S_INIT_WR,
		S_WALK_RD,
		S_WALK_CHK,
		S_WALK_ACT,
		S_NEXT,
		S_MF_TEST,
		S_MF_RD,
		S_MF_CHK,
		S_MF_SUM,
		S_PICK,
		S_SCAN_END,
		S_HDR_RD,
		S_HDR_CHK,
		S_OWN_WR,
		S_RSZ,
		S_TL_RD,
		S_TL_CHK,
		S_TL_RS,
		S_TL_REST,
		S_TL_FIN,
		S_TH_DIFF,
		S_TH_US,
		S_TH_UP,
		S_TH_LOW,
		S_TH_BLK,
		S_DONE
	} paa_state_t;

endpackage

### rtl/paa_ram.sv
// ----------------------------------------------------------------------------
// paa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module paa_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/paa_alu.sv
// ----------------------------------------------------------------------------
// paa_alu
// Shared 16-bit adder/subtractor with carry out, used by the steps of the
// sequencer for segment sums, size splits and range checks.
// ----------------------------------------------------------------------------
module paa_alu (
	input  logic [15:0] a,
	input  logic [15:0] b,
	input  logic        sub,
	input  logic        cin,
	output logic [16:0] sum
);

	logic [15:0] b_op;

	// subtract as a + ~b + cin
	assign b_op = sub ? ~b : b;
	assign sum  = {1'b0, a} + {1'b0, b_op} + {16'd0, cin};

endmodule

### rtl/paa_engine.sv
// ----------------------------------------------------------------------------
// paa_engine
// Sequencer that walks the header chain one block per store read, merges
// free neighbours and splits blocks, its chain and size sums through one shared adder.
// ----------------------------------------------------------------------------
module paa_engine
	import paa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  paa_in_t     req,
	input  logic        out_free,
	input  logic [1:0]  fit_strategy,
	input  logic [15:0] arena_start,
	input  logic [15:0] arena_end,
	input  hdr_t        rd_data,
	output mem_req_t    mem,
	output eng_stat_t   stat,
	output paa_out_t    result
);

	paa_state_t state_q, state_d;

	// request fields
	logic [3:0]  op_q;
	logic [15:0] hseg_q, owner_q, nown_q, req_q;

	// walk registers
	logic [15:0] seg_q, nx_q, f_size_q;
	logic [7:0]  f_mark_q;
	hdr_t        h_q;

	// scan picks
	logic        found_q;
	logic [15:0] first_q, best_q, best_sz_q, last_q, max_q;

	logic        hi_q, ready_q;
	logic [2:0]  sts_q;
	logic [15:0] blk_q, lf_q;

	// shared adder
	logic [15:0] alu_a, alu_b;
	logic        alu_sub, alu_cin;
	logic [16:0] alu_sum;
	logic [15:0] sum;
	logic        cy;

	// store port
	logic [15:0] mem_seg, idx;
	logic        in_range, mem_we, rd_ok;
	hdr_t        mem_wdata;

	logic        fin_en;
	logic [2:0]  fin_sts;
	logic        merge_to_rsz;

	paa_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.cin (alu_cin),
		.sum (alu_sum)
	);

	assign sum = alu_sum[15:0];
	assign cy  = alu_sum[16];

	// segment to store entry
	assign idx      = mem_seg - arena_start;
	assign in_range = {1'b0, idx} < 17'(ARENA_PARAGRAPHS);
	assign mem.addr  = idx[ADDR_W-1:0];
	assign mem.we    = mem_we && in_range;
	assign mem.wdata = mem_wdata;

	assign rd_ok        = (rd_data.mark == MARK_INNER) || (rd_data.mark == MARK_LAST);
	assign merge_to_rsz = (op_q == OP_RESIZE);

	assign result    = '{status: sts_q, result_block: blk_q, largest_free: lf_q};

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, adder operands, store port
	always_comb begin
		state_d        = state_q;
		fin_en         = 1'b0;
		fin_sts        = STS_OK;
		alu_a          = seg_q;
		alu_b          = h_q.size;
		alu_sub        = 1'b0;
		alu_cin        = 1'b0;
		mem_seg        = seg_q;
		mem_we         = 1'b0;
		mem_wdata      = h_q;
		stat.idle      = (state_q == S_IDLE);
		stat.load      = 1'b0;
		stat.strat_clr = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (op_q == OP_INIT) begin
					state_d = S_INIT;
				end else if (op_q > OP_VALIDATE || !ready_q) begin
					fin_en  = 1'b1;
					fin_sts = STS_BAD_ARG;
				end else if (op_q inside {OP_FREE, OP_RESIZE}) begin
					state_d = S_HDR_RD;
				end else if (op_q inside {OP_FREE_OWNED, OP_TRANSFER}) begin
					if (owner_q == 16'd0 || (op_q == OP_TRANSFER && nown_q == 16'd0)) begin
						fin_en  = 1'b1;
						fin_sts = STS_BAD_ARG;
					end else begin
						state_d = S_WALK_RD;
					end
				end else begin
					state_d = S_WALK_RD;
				end
			end
			S_INIT: begin
				alu_a   = arena_end;
				alu_b   = arena_start;
				alu_sub = 1'b1;
				alu_cin = 1'b1;
				if (cy && sum != 16'd0) begin
					state_d = S_INIT_WR;
				end else begin
					fin_en  = 1'b1;
					fin_sts = STS_BAD_ARG;
				end
			end
			S_INIT_WR: begin
				alu_a          = arena_end;
				alu_b          = arena_start;
				alu_sub        = 1'b1;
				mem_seg        = arena_start;
				mem_we         = 1'b1;
				mem_wdata      = '{size: sum, owner: 16'd0, mark: MARK_LAST};
				stat.strat_clr = 1'b1;
				fin_en         = 1'b1;
			end
			S_WALK_RD: begin
				if (!in_range) begin
					fin_en  = 1'b1;
					fin_sts = STS_STORE;
				end else begin
					state_d = S_WALK_CHK;
				end
			end
			S_WALK_CHK: begin
				alu_b = rd_data.size;
				if (!rd_ok || cy) begin
					fin_en  = 1'b1;
					fin_sts = STS_DAMAGED;
				end else begin
					state_d = S_WALK_ACT;
				end
			end
			S_WALK_ACT: begin
				if (op_q inside {OP_ALLOC, OP_QUERY_MAX}) begin
					if (h_q.owner == 16'd0) begin
						state_d = S_MF_TEST;
					end else if (h_q.mark == MARK_LAST) begin
						state_d = S_SCAN_END;
					end else begin
						state_d = S_NEXT;
					end
				end else if (op_q inside {OP_FREE_OWNED, OP_TRANSFER}) begin
					// locate: hseg below seg means the header is not on the chain
					alu_a   = hseg_q;
					alu_b   = seg_q;
					alu_sub = 1'b1;
					alu_cin = 1'b1;
					if (seg_q == hseg_q) begin
						state_d = S_OWN_WR;
					end else if (!cy || h_q.mark == MARK_LAST) begin
						fin_en  = 1'b1;
						fin_sts = STS_BAD_BLOCK;
					end else begin
						state_d = S_NEXT;
					end
				end else begin
					if (op_q == OP_FREE_OWNER && h_q.owner == owner_q) begin
						mem_we    = 1'b1;
						mem_wdata = '{size: h_q.size, owner: 16'd0, mark: h_q.mark};
					end
					if (h_q.mark == MARK_LAST) begin
						fin_en = 1'b1;
					end else begin
						state_d = S_NEXT;
					end
				end
			end
			S_NEXT: begin
				alu_cin = 1'b1;
				if (cy) begin
					fin_en  = 1'b1;
					fin_sts = STS_DAMAGED;
				end else begin
					state_d = S_WALK_RD;
				end
			end
			S_MF_TEST: begin
				alu_cin = 1'b1;
				if (h_q.mark == MARK_LAST) begin
					state_d = merge_to_rsz ? S_RSZ : S_PICK;
				end else if (cy) begin
					fin_en  = 1'b1;
					fin_sts = STS_DAMAGED;
				end else begin
					state_d = S_MF_RD;
				end
			end
			S_MF_RD: begin
				mem_seg = nx_q;
				if (!in_range) begin
					fin_en  = 1'b1;
					fin_sts = STS_STORE;
				end else begin
					state_d = S_MF_CHK;
				end
			end
			S_MF_CHK: begin
				alu_a = nx_q;
				alu_b = rd_data.size;
				if (!rd_ok || cy) begin
					fin_en  = 1'b1;
					fin_sts = STS_DAMAGED;
				end else if (rd_data.owner != 16'd0) begin
					state_d = merge_to_rsz ? S_RSZ : S_PICK;
				end else begin
					state_d = S_MF_SUM;
				end
			end
			S_MF_SUM: begin
				alu_a   = h_q.size;
				alu_b   = f_size_q;
				alu_cin = 1'b1;
				if (cy) begin
					fin_en  = 1'b1;
					fin_sts = STS_DAMAGED;
				end else begin
					mem_we    = 1'b1;
					mem_wdata = '{size: sum, owner: h_q.owner, mark: f_mark_q};
					state_d   = S_MF_TEST;
				end
			end
			S_PICK: begin
				state_d = (h_q.mark == MARK_LAST) ? S_SCAN_END : S_NEXT;
			end
			S_SCAN_END: begin
				if (op_q == OP_QUERY_MAX) begin
					fin_en = 1'b1;
				end else if (!found_q) begin
					fin_en  = 1'b1;
					fin_sts = STS_NO_MEM;
				end else begin
					state_d = S_TL_RD;
				end
			end
			S_HDR_RD: begin
				mem_seg = hseg_q;
				if (!in_range) begin
					fin_en  = 1'b1;
					fin_sts = STS_STORE;
				end else begin
					state_d = S_HDR_CHK;
				end
			end
			S_HDR_CHK: begin
				alu_a = hseg_q;
				alu_b = rd_data.size;
				if (op_q == OP_FREE) begin
					if (!rd_ok) begin
						fin_en  = 1'b1;
						fin_sts = STS_BAD_BLOCK;
					end else begin
						state_d = S_OWN_WR;
					end
				end else if (!rd_ok || cy) begin
					fin_en  = 1'b1;
					fin_sts = STS_DAMAGED;
				end else begin
					state_d = S_MF_TEST;
				end
			end
			S_OWN_WR: begin
				mem_seg = hseg_q;
				fin_en  = 1'b1;
				if (op_q != OP_FREE && h_q.owner != owner_q) begin
					fin_sts = STS_MISMATCH;
				end else begin
					mem_we    = 1'b1;
					mem_wdata = '{size: h_q.size,
						owner: (op_q == OP_TRANSFER) ? nown_q : 16'd0, mark: h_q.mark};
				end
			end
			S_RSZ: begin
				if (req_q > h_q.size) begin
					fin_en  = 1'b1;
					fin_sts = STS_NO_MEM;
				end else begin
					state_d = S_TL_RD;
				end
			end
			S_TL_RD: begin
				if (!in_range) begin
					fin_en  = 1'b1;
					fin_sts = STS_STORE;
				end else begin
					state_d = S_TL_CHK;
				end
			end
			S_TL_CHK: begin
				alu_b = rd_data.size;
				if (!rd_ok || cy || req_q > rd_data.size) begin
					fin_en  = 1'b1;
					fin_sts = STS_DAMAGED;
				end else if (req_q == rd_data.size) begin
					state_d = S_TL_FIN;
				end else begin
					state_d = hi_q ? S_TH_DIFF : S_TL_RS;
				end
			end
			S_TL_RS: begin
				alu_b   = req_q;
				alu_cin = 1'b1;
				if (cy) begin
					fin_en  = 1'b1;
					fin_sts = STS_DAMAGED;
				end else begin
					state_d = S_TL_REST;
				end
			end
			S_TL_REST: begin
				// remainder size = size - req - 1
				mem_seg = nx_q;
				alu_a   = h_q.size;
				alu_b   = req_q;
				alu_sub = 1'b1;
				if (!in_range) begin
					fin_en  = 1'b1;
					fin_sts = STS_STORE;
				end else begin
					mem_we    = 1'b1;
					mem_wdata = '{size: sum, owner: 16'd0, mark: h_q.mark};
					state_d   = S_TL_FIN;
				end
			end
			S_TL_FIN: begin
				alu_b     = 16'd0;
				alu_cin   = 1'b1;
				mem_we    = 1'b1;
				mem_wdata = '{size: h_q.size, owner: owner_q, mark: h_q.mark};
				fin_en    = 1'b1;
			end
			S_TH_DIFF: begin
				alu_a   = h_q.size;
				alu_b   = req_q;
				alu_sub = 1'b1;
				alu_cin = 1'b1;
				state_d = S_TH_US;
			end
			S_TH_US: begin
				alu_b = f_size_q;
				if (cy) begin
					fin_en  = 1'b1;
					fin_sts = STS_DAMAGED;
				end else begin
					state_d = S_TH_UP;
				end
			end
			S_TH_UP: begin
				mem_seg = nx_q;
				if (!in_range) begin
					fin_en  = 1'b1;
					fin_sts = STS_STORE;
				end else begin
					mem_we    = 1'b1;
					mem_wdata = '{size: req_q, owner: owner_q, mark: h_q.mark};
					state_d   = S_TH_LOW;
				end
			end
			S_TH_LOW: begin
				// lower free part keeps diff - 1 paragraphs
				alu_a     = f_size_q;
				alu_b     = 16'd0;
				alu_sub   = 1'b1;
				mem_we    = 1'b1;
				mem_wdata = '{size: sum, owner: 16'd0, mark: MARK_INNER};
				state_d   = S_TH_BLK;
			end
			S_TH_BLK: begin
				alu_a   = nx_q;
				alu_b   = 16'd0;
				alu_cin = 1'b1;
				fin_en  = 1'b1;
			end
			S_DONE: begin
				if (out_free) begin
					stat.load = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin_en) begin
			state_d = S_DONE;
		end
	end

	// arena ready flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else if (stat.strat_clr) begin
			ready_q <= 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (fin_en) begin
			sts_q <= fin_sts;
		end
		case (state_q)
			S_IDLE: begin
				op_q    <= req.operation;
				hseg_q  <= req.block_address - 16'd1;
				owner_q <= req.owner;
				nown_q  <= req.next_owner;
				req_q   <= req.paragraphs;
				sts_q   <= STS_OK;
				blk_q   <= 16'd0;
				lf_q    <= 16'd0;
			end
			S_DISP: begin
				seg_q   <= arena_start;
				found_q <= 1'b0;
				max_q   <= 16'd0;
				hi_q    <= 1'b0;
				if (op_q == OP_QUERY_MAX) begin
					req_q <= SEG_MAX;
				end
			end
			S_WALK_CHK, S_TL_CHK: begin
				h_q <= rd_data;
			end
			S_HDR_CHK: begin
				h_q   <= rd_data;
				seg_q <= hseg_q;
			end
			S_NEXT: begin
				seg_q <= sum;
			end
			S_MF_TEST, S_TL_RS, S_TH_US: begin
				nx_q <= sum;
			end
			S_MF_CHK: begin
				f_size_q <= rd_data.size;
				f_mark_q <= rd_data.mark;
			end
			S_MF_SUM: begin
				h_q.size <= sum;
				h_q.mark <= f_mark_q;
			end
			S_PICK: begin
				if (h_q.size > max_q) begin
					max_q <= h_q.size;
				end
				if (h_q.size >= req_q) begin
					if (!found_q) begin
						found_q   <= 1'b1;
						first_q   <= seg_q;
						best_q    <= seg_q;
						best_sz_q <= h_q.size;
					end else if (h_q.size < best_sz_q) begin
						best_q    <= seg_q;
						best_sz_q <= h_q.size;
					end
					last_q <= seg_q;
				end
			end
			S_SCAN_END: begin
				lf_q <= max_q;
				hi_q <= fit_strategy[1];
				case (fit_strategy)
					FIT_FIRST: seg_q <= first_q;
					FIT_BEST:  seg_q <= best_q;
					default:   seg_q <= last_q;
				endcase
			end
			S_RSZ: begin
				lf_q <= h_q.size;
			end
			S_TL_REST: begin
				h_q.mark <= MARK_INNER;
				h_q.size <= req_q;
			end
			S_TL_FIN: begin
				if (op_q == OP_ALLOC) begin
					blk_q <= sum;
				end
			end
			S_TH_DIFF: begin
				f_size_q <= sum;
			end
			S_TH_BLK: begin
				blk_q <= sum;
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/paragraph_arena_allocator.sv
// ----------------------------------------------------------------------------
// paragraph_arena_allocator
// Block header chain allocator over a paragraph-granular arena: init, first/
// best/last fit allocate, free, checked free, resize, free by owner, query,
// transfer and validate, one request at a time.
//
//   channel  direction  handshake        beat
//   req      in         req_valid/stall  paa_in_t request
//   rsp      out        rsp_valid/stall  paa_out_t result
//   cfg      in         cfg_valid/ready  register index and data
//
// Each chain step is one read of the header store, so the chain length sets
// how long a request takes; merging free neighbours and splitting add steps.
// After reset a clearing pass writes every header entry to zero, and
// req_stall is high while it runs. A result waits in the output register
// while the next request is taken; a finished request holds the sequencer
// until that register is free.
// ----------------------------------------------------------------------------
module paragraph_arena_allocator
	import paa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  paa_in_t     req_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output paa_out_t    rsp_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [1:0]  fit_q;
	logic [15:0] start_q, end_q;

	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_q;

	mem_req_t  eng_mem;
	eng_stat_t eng_stat;
	paa_out_t  eng_result;
	hdr_t      rd_hdr;
	logic [39:0] ram_rdata;

	logic req_acc, out_free;

	assign cfg_ready = 1'b1;
	assign req_stall = !eng_stat.idle || clr_busy_q;
	assign req_acc   = req_valid && !req_stall;
	assign out_free  = !rsp_valid || !rsp_stall;
	assign rd_hdr    = hdr_t'(ram_rdata);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_q   <= FIT_FIRST;
			start_q <= 16'd0;
			end_q   <= ARENA_END_RST;
		end else if (eng_stat.strat_clr) begin
			fit_q <= FIT_FIRST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FIT:   fit_q   <= cfg_data[1:0];
				CFG_START: start_q <= cfg_data;
				CFG_END:   end_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// clearing pass over the header store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + ADDR_W'(1);
			if (clr_q == ADDR_W'(ARENA_PARAGRAPHS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (eng_stat.load) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_stat.load) begin
			rsp_data <= eng_result;
		end
	end

	paa_ram #(
		.WIDTH (40),
		.DEPTH (ARENA_PARAGRAPHS)
	) u_store (
		.clk   (clk),
		.we    (clr_busy_q || eng_mem.we),
		.waddr (clr_busy_q ? clr_q : eng_mem.addr),
		.wdata (clr_busy_q ? 40'd0 : eng_mem.wdata),
		.raddr (eng_mem.addr),
		.rdata (ram_rdata)
	);

	paa_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (req_acc),
		.req          (req_data),
		.out_free     (out_free),
		.fit_strategy (fit_q),
		.arena_start  (start_q),
		.arena_end    (end_q),
		.rd_data      (rd_hdr),
		.mem          (eng_mem),
		.stat         (eng_stat),
		.result       (eng_result)
	);

	// no engine store write while the clearing pass owns the port
	a_clr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !eng_mem.we)
		else $error("engine write during clearing pass");

	// a result is loaded only into a free output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		eng_stat.load |-> (!rsp_valid || !rsp_stall))
		else $error("result overwrote a waiting beat");

	// an accepted request starts the sequencer
	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !eng_stat.idle)
		else $error("accepted request not started");

endmodule

### tb/paragraph_arena_allocator_test.sv
// ----------------------------------------------------------------------------
// paragraph_arena_allocator_test
// Self-checking bench for the arena allocator. A predictor keeps its own copy
// of the header store and registers and works out the result beat of every
// accepted request. Directed tests cover each operation, the error statuses
// and the arena range extremes. Random phases then run allocate/free/resize
// traffic on live blocks, mixed with noise, under random valid and stall gaps.
// ----------------------------------------------------------------------------
module paragraph_arena_allocator_test;
	import paa_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	paa_in_t     req_data;
	logic        rsp_valid;
	logic        rsp_stall;
	paa_out_t    rsp_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	paragraph_arena_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor state
	hdr_t        hdr_mem [ARENA_PARAGRAPHS];
	logic        arena_up;
	logic [1:0]  fit_mode;
	int unsigned arena_base;
	int unsigned arena_limit;

	paa_out_t    due_results [$];
	logic [15:0] live_blocks [$];
	int          fail_count;
	logic        no_idle;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		#200000000;
		$display("[paragraph_arena_allocator] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Header store model
	// ------------------------------------------------------------------
	function automatic logic [2:0] hdr_read(input int unsigned seg, output hdr_t h);
		int unsigned i;
		i = (seg - arena_base) & 32'hffff;
		h = '0;
		if (i >= ARENA_PARAGRAPHS) return STS_STORE;
		h = hdr_mem[i];
		return STS_OK;
	endfunction

	function automatic logic [2:0] hdr_write(input int unsigned seg, input hdr_t h);
		int unsigned i;
		i = (seg - arena_base) & 32'hffff;
		if (i >= ARENA_PARAGRAPHS) return STS_STORE;
		hdr_mem[i] = h;
		return STS_OK;
	endfunction

	function automatic logic mark_good(input hdr_t h);
		return h.mark == MARK_INNER || h.mark == MARK_LAST;
	endfunction

	// read plus mark and extent check
	function automatic logic [2:0] hdr_fetch(input int unsigned seg, output hdr_t h);
		logic [2:0] st;
		st = hdr_read(seg, h);
		if (st != STS_OK) return st;
		if (!mark_good(h) || h.size > 32'hffff - seg) return STS_DAMAGED;
		return STS_OK;
	endfunction

	function automatic logic [2:0] chain_next(input int unsigned seg, input hdr_t h,
			output int unsigned nx);
		int unsigned v;
		v = seg + h.size + 1;
		nx = 0;
		if (v > 32'hffff || v <= seg) return STS_DAMAGED;
		nx = v;
		return STS_OK;
	endfunction

	// absorb the free blocks that follow seg
	function automatic logic [2:0] merge_fwd(input int unsigned seg, inout hdr_t h);
		int unsigned steps, fs, sum;
		hdr_t        f;
		logic [2:0]  st;
		steps = 0;
		while (h.mark != MARK_LAST) begin
			steps++;
			if (steps > 65536) return STS_DAMAGED;
			st = chain_next(seg, h, fs);
			if (st != STS_OK) return st;
			st = hdr_fetch(fs, f);
			if (st != STS_OK) return st;
			if (f.owner != 0) break;
			sum = h.size + f.size + 1;
			if (sum > 32'hffff) return STS_DAMAGED;
			h.size = sum[15:0];
			h.mark = f.mark;
			st = hdr_write(seg, h);
			if (st != STS_OK) return st;
		end
		return STS_OK;
	endfunction

	// chain walk collecting fit candidates
	function automatic logic [2:0] fit_scan(input int unsigned req, output logic found,
			output int unsigned first, output int unsigned best,
			output int unsigned last, output int unsigned maxsz);
		int unsigned seg, steps, nx, bsize;
		hdr_t        h;
		logic [2:0]  st;
		found = 1'b0;
		first = 0;
		best = 0;
		last = 0;
		maxsz = 0;
		bsize = 0;
		seg = arena_base;
		for (steps = 0; steps < 65536; steps++) begin
			st = hdr_fetch(seg, h);
			if (st != STS_OK) return st;
			if (h.owner == 0) begin
				st = merge_fwd(seg, h);
				if (st != STS_OK) return st;
				if (h.size > maxsz) maxsz = h.size;
				if (h.size >= req) begin
					if (!found) begin
						first = seg;
						best = seg;
						bsize = h.size;
						found = 1'b1;
					end else if (h.size < bsize) begin
						best = seg;
						bsize = h.size;
					end
					last = seg;
				end
			end
			if (h.mark == MARK_LAST) return STS_OK;
			st = chain_next(seg, h, nx);
			if (st != STS_OK) return st;
			seg = nx;
		end
		return STS_DAMAGED;
	endfunction

	function automatic logic [2:0] split_low(input int unsigned seg, input int unsigned req,
			input logic [15:0] own, output int unsigned blk);
		hdr_t        cur, rest;
		int unsigned rs;
		logic [2:0]  st;
		blk = 0;
		st = hdr_fetch(seg, cur);
		if (st != STS_OK) return st;
		if (req > cur.size) return STS_DAMAGED;
		if (req < cur.size) begin
			rs = seg + req + 1;
			if (rs > 32'hffff) return STS_DAMAGED;
			st = hdr_read(rs, rest);
			if (st != STS_OK) return st;
			rest.mark = cur.mark;
			rest.owner = '0;
			rest.size = 16'(cur.size - req - 1);
			st = hdr_write(rs, rest);
			if (st != STS_OK) return st;
			cur.mark = MARK_INNER;
			cur.size = 16'(req);
		end
		cur.owner = own;
		st = hdr_write(seg, cur);
		if (st == STS_OK) blk = (seg + 1) & 32'hffff;
		return st;
	endfunction

	function automatic logic [2:0] split_high(input int unsigned seg, input int unsigned req,
			input logic [15:0] own, output int unsigned blk);
		hdr_t        low, up;
		int unsigned diff, us;
		logic [2:0]  st;
		blk = 0;
		st = hdr_fetch(seg, low);
		if (st != STS_OK) return st;
		if (req > low.size) return STS_DAMAGED;
		if (req == low.size) return split_low(seg, req, own, blk);
		diff = low.size - req;
		us = seg + diff;
		if (us > 32'hffff) return STS_DAMAGED;
		st = hdr_read(us, up);
		if (st != STS_OK) return st;
		up.mark = low.mark;
		up.size = 16'(req);
		up.owner = own;
		st = hdr_write(us, up);
		if (st != STS_OK) return st;
		low.mark = MARK_INNER;
		low.size = 16'(diff - 1);
		low.owner = '0;
		st = hdr_write(seg, low);
		if (st == STS_OK) blk = (us + 1) & 32'hffff;
		return st;
	endfunction

	function automatic logic [2:0] find_on_chain(input int unsigned wanted, output hdr_t hout);
		int unsigned seg, steps, nx;
		hdr_t        h;
		logic [2:0]  st;
		hout = '0;
		seg = arena_base;
		for (steps = 0; steps < 65536; steps++) begin
			st = hdr_fetch(seg, h);
			if (st != STS_OK) return st;
			if (seg == wanted) begin
				hout = h;
				return STS_OK;
			end
			if (wanted < seg || h.mark == MARK_LAST) return STS_BAD_BLOCK;
			st = chain_next(seg, h, nx);
			if (st != STS_OK) return st;
			seg = nx;
		end
		return STS_DAMAGED;
	endfunction

	function automatic logic [2:0] chain_sweep(input logic release_own, input logic [15:0] own);
		int unsigned seg, steps, nx;
		hdr_t        h;
		logic [2:0]  st;
		seg = arena_base;
		for (steps = 0; steps < 65536; steps++) begin
			st = hdr_fetch(seg, h);
			if (st != STS_OK) return st;
			if (release_own && h.owner == own) begin
				h.owner = '0;
				st = hdr_write(seg, h);
				if (st != STS_OK) return st;
			end
			if (h.mark == MARK_LAST) return STS_OK;
			st = chain_next(seg, h, nx);
			if (st != STS_OK) return st;
			seg = nx;
		end
		return STS_DAMAGED;
	endfunction

	// expected result beat of one request; updates the model
	function automatic paa_out_t alloc_outcome(input paa_in_t it);
		paa_out_t    r;
		logic [2:0]  st;
		int unsigned hseg, blk, lf, first, best, last, maxsz, dummy;
		logic        found, checked;
		hdr_t        h;
		hseg = (it.block_address - 1) & 32'hffff;
		blk = 0;
		lf = 0;
		st = STS_OK;
		if (it.operation == OP_INIT) begin
			if (arena_limit <= arena_base) begin
				st = STS_BAD_ARG;
			end else begin
				h.mark = MARK_LAST;
				h.owner = '0;
				h.size = 16'(arena_limit - arena_base - 1);
				st = hdr_write(arena_base, h);
				if (st == STS_OK) begin
					arena_up = 1'b1;
					fit_mode = FIT_FIRST;
				end
			end
		end else if (it.operation > OP_VALIDATE || !arena_up) begin
			st = STS_BAD_ARG;
		end else if (it.operation == OP_ALLOC) begin
			st = fit_scan(it.paragraphs, found, first, best, last, maxsz);
			if (st == STS_OK) begin
				lf = maxsz;
				if (!found) st = STS_NO_MEM;
				else if (fit_mode == FIT_FIRST) st = split_low(first, it.paragraphs, it.owner, blk);
				else if (fit_mode == FIT_BEST) st = split_low(best, it.paragraphs, it.owner, blk);
				else st = split_high(last, it.paragraphs, it.owner, blk);
			end
		end else if (it.operation == OP_FREE || it.operation == OP_FREE_OWNED ||
				it.operation == OP_TRANSFER) begin
			checked = it.operation != OP_FREE;
			h = '0;
			if (checked && (it.owner == 0 ||
					(it.operation == OP_TRANSFER && it.next_owner == 0))) begin
				st = STS_BAD_ARG;
			end else if (checked) begin
				st = find_on_chain(hseg, h);
			end else begin
				st = hdr_read(hseg, h);
				if (st == STS_OK && !mark_good(h)) st = STS_BAD_BLOCK;
			end
			if (st == STS_OK && checked && h.owner != it.owner) st = STS_MISMATCH;
			if (st == STS_OK) begin
				h.owner = (it.operation == OP_TRANSFER) ? it.next_owner : 16'd0;
				st = hdr_write(hseg, h);
			end
		end else if (it.operation == OP_RESIZE) begin
			st = hdr_fetch(hseg, h);
			if (st == STS_OK) st = merge_fwd(hseg, h);
			if (st == STS_OK) begin
				lf = h.size;
				if (it.paragraphs > h.size) st = STS_NO_MEM;
				else st = split_low(hseg, it.paragraphs, it.owner, dummy);
			end
		end else if (it.operation == OP_FREE_OWNER) begin
			st = chain_sweep(1'b1, it.owner);
		end else if (it.operation == OP_QUERY_MAX) begin
			st = fit_scan(32'hffff, found, first, best, last, maxsz);
			if (st == STS_OK) lf = maxsz;
		end else begin
			st = chain_sweep(1'b0, 16'd0);
		end
		r.status = st;
		r.result_block = blk[15:0];
		r.largest_free = lf[15:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------
	task automatic send_req(input logic [3:0] op, input logic [15:0] addr,
			input logic [15:0] own, input logic [15:0] nown, input logic [15:0] par,
			output paa_out_t exp_beat);
		paa_in_t it;
		int      gap;
		it.operation = op;
		it.block_address = addr;
		it.owner = own;
		it.next_owner = nown;
		it.paragraphs = par;
		gap = no_idle ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= it;
		exp_beat = alloc_outcome(it);
		due_results.push_back(exp_beat);
		if (op == OP_ALLOC && exp_beat.status == STS_OK) begin
			live_blocks.push_back(exp_beat.result_block);
			if (live_blocks.size() > 64) void'(live_blocks.pop_front());
		end
		do @(posedge clk); while (req_stall);
	endtask

	task automatic send(input logic [3:0] op, input logic [15:0] addr,
			input logic [15:0] own, input logic [15:0] nown, input logic [15:0] par);
		paa_out_t unused;
		send_req(op, addr, own, nown, par, unused);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain();
		req_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
		drain();
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_FIT) fit_mode = val[1:0];
		else if (idx == CFG_START) arena_base = val;
		else if (idx == CFG_END) arena_limit = val;
	endtask

	task automatic set_arena(input logic [15:0] s, input logic [15:0] e);
		cfg_write(CFG_START, s);
		cfg_write(CFG_END, e);
		live_blocks.delete();
	endtask

	// ------------------------------------------------------------------
	// Result side: random stall per beat, compare with oldest expectation
	// ------------------------------------------------------------------
	initial begin
		int       hold;
		paa_out_t exp_beat;
		@(posedge arst_n);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 17);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!(rsp_valid && !rsp_stall));
			if (due_results.size() == 0) begin
				$error("unexpected result beat %h", rsp_data);
				fail_count++;
			end else begin
				exp_beat = due_results.pop_front();
				if (rsp_data.status !== exp_beat.status) begin
					$error("status: expected %0d, got %0d", exp_beat.status, rsp_data.status);
					fail_count++;
				end
				if (rsp_data.result_block !== exp_beat.result_block) begin
					$error("result_block: expected %h, got %h",
						exp_beat.result_block, rsp_data.result_block);
					fail_count++;
				end
				if (rsp_data.largest_free !== exp_beat.largest_free) begin
					$error("largest_free: expected %h, got %h",
						exp_beat.largest_free, rsp_data.largest_free);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// requests before any init, and an init over an empty range
	task automatic test_not_ready();
		send(OP_VALIDATE, 16'd1, 16'd0, 16'd1, 16'd0);
		send(4'd15, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		set_arena(16'd100, 16'd50);
		send(OP_INIT, 16'd0, 16'd0, 16'd1, 16'd0);
	endtask

	// every operation and its error statuses on a small chain
	task automatic test_operations();
		paa_out_t a, b;
		set_arena(16'd0, ARENA_END_RST);
		send(OP_INIT, 16'd0, 16'd0, 16'd1, 16'd0);
		send_req(OP_ALLOC, 16'd0, 16'd1, 16'd1, 16'd10, a);
		send(OP_ALLOC, 16'd0, 16'd1, 16'd1, 16'hffff);
		send_req(OP_ALLOC, 16'd0, 16'd2, 16'd1, 16'd20, b);
		send(OP_FREE_OWNED, a.result_block, 16'd2, 16'd1, 16'd0);
		send(OP_FREE_OWNED, a.result_block, 16'd0, 16'd1, 16'd0);
		send(OP_TRANSFER, b.result_block, 16'd2, 16'd3, 16'd0);
		send(OP_TRANSFER, b.result_block, 16'd3, 16'd0, 16'd0);
		send(OP_RESIZE, b.result_block, 16'd3, 16'd1, 16'd40);
		send(OP_RESIZE, b.result_block, 16'd3, 16'd1, 16'd5);
		send(OP_FREE, a.result_block, 16'd0, 16'd1, 16'd0);
		send(OP_FREE, 16'd2000, 16'd0, 16'd1, 16'd0);
		send(OP_FREE_OWNED, 16'd3, 16'd3, 16'd1, 16'd0);
		send(OP_FREE_OWNER, 16'd0, 16'd3, 16'd1, 16'd0);
		send(OP_QUERY_MAX, 16'd0, 16'd0, 16'd1, 16'd0);
		send(OP_VALIDATE, 16'd0, 16'd0, 16'd1, 16'd0);
		send(OP_ALLOC, 16'd0, 16'd0, 16'd1, 16'd0);
	endtask

	// first, best and last fit (strategy three behaves as last)
	task automatic test_fit_modes();
		paa_out_t a, c;
		set_arena(16'd0, ARENA_END_RST);
		send(OP_INIT, 16'd0, 16'd0, 16'd1, 16'd0);
		send_req(OP_ALLOC, 16'd0, 16'd1, 16'd1, 16'd30, a);
		send(OP_ALLOC, 16'd0, 16'd1, 16'd1, 16'd5);
		send_req(OP_ALLOC, 16'd0, 16'd1, 16'd1, 16'd10, c);
		send(OP_ALLOC, 16'd0, 16'd1, 16'd1, 16'd5);
		send(OP_FREE, a.result_block, 16'd0, 16'd1, 16'd0);
		send(OP_FREE, c.result_block, 16'd0, 16'd1, 16'd0);
		cfg_write(CFG_FIT, FIT_BEST);
		send(OP_ALLOC, 16'd0, 16'd2, 16'd1, 16'd8);
		cfg_write(CFG_FIT, FIT_LAST);
		send(OP_ALLOC, 16'd0, 16'd2, 16'd1, 16'd4);
		cfg_write(CFG_FIT, 2'd3);
		send(OP_ALLOC, 16'd0, 16'd2, 16'd1, 16'd4);
		send(OP_VALIDATE, 16'd0, 16'd0, 16'd1, 16'd0);
	endtask

	// arena placement extremes: top of segment space, past the store, tiny
	task automatic test_arena_edges();
		set_arena(16'hf000, 16'hffff);
		send(OP_INIT, 16'd0, 16'd0, 16'd1, 16'd0);
		send(OP_ALLOC, 16'd0, 16'd1, 16'd1, 16'd100);
		send(OP_VALIDATE, 16'd0, 16'd0, 16'd1, 16'd0);
		set_arena(16'd0, 16'hffff);
		send(OP_INIT, 16'd0, 16'd0, 16'd1, 16'd0);
		send(OP_ALLOC, 16'd0, 16'd1, 16'd1, 16'd5000);
		send(OP_ALLOC, 16'd0, 16'd1, 16'd1, 16'd10);
		set_arena(16'hffff, 16'd1);
		send(OP_INIT, 16'd0, 16'd0, 16'd1, 16'd0);
		set_arena(16'd0, 16'd1);
		send(OP_INIT, 16'd0, 16'd0, 16'd1, 16'd0);
		send(OP_ALLOC, 16'd0, 16'd1, 16'd1, 16'd0);
		// chain start moved into stale headers without an init
		set_arena(16'd7, 16'd4000);
		send(OP_VALIDATE, 16'd0, 16'd0, 16'd1, 16'd0);
	endtask

	function automatic logic [15:0] pick_owner();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return 16'd0;
		if (r < 10) return 16'($urandom_range(0, 16'hffff));
		return 16'($urandom_range(1, 4));
	endfunction

	task automatic random_item();
		int          r, sel;
		logic [3:0]  op;
		logic [15:0] addr, par;
		r = $urandom_range(0, 99);
		if (r < 32) op = OP_ALLOC;
		else if (r < 44) op = OP_FREE;
		else if (r < 54) op = OP_FREE_OWNED;
		else if (r < 66) op = OP_RESIZE;
		else if (r < 72) op = OP_FREE_OWNER;
		else if (r < 78) op = OP_QUERY_MAX;
		else if (r < 87) op = OP_TRANSFER;
		else if (r < 94) op = OP_VALIDATE;
		else if (r < 95) op = OP_INIT;
		else op = 4'($urandom_range(9, 15));
		if (live_blocks.size() != 0 && $urandom_range(0, 99) < 80) begin
			sel = $urandom_range(0, live_blocks.size() - 1);
			addr = live_blocks[sel];
		end else begin
			addr = 16'($urandom_range(0, 16'hffff));
		end
		r = $urandom_range(0, 99);
		if (r < 5) par = 16'd0;
		else if (r < 10) par = 16'($urandom_range(0, 16'hffff));
		else par = 16'($urandom_range(1, 200));
		send(op, addr, pick_owner(), pick_owner(), par);
	endtask

	// random traffic over several arena placements and fit modes
	task automatic test_random_traffic();
		int          ph, n;
		int unsigned s, e;
		for (ph = 0; ph < 6; ph++) begin
			r_place: begin
				case (ph % 3)
					0: s = 0;
					1: s = $urandom_range(0, 16'he000);
					default: s = 16'hf000;
				endcase
			end
			e = s + (($urandom_range(0, 3) == 0) ? 5000 : $urandom_range(64, 4096));
			if (e > 16'hffff) e = 16'hffff;
			set_arena(s[15:0], e[15:0]);
			no_idle = (ph % 3 == 1);
			send(OP_INIT, 16'd0, 16'd0, 16'd1, 16'd0);
			cfg_write(CFG_FIT, 2'($urandom_range(0, 3)));
			for (n = 0; n < 320; n++) begin
				if (n == 160) begin
					if (ph == 2) drain();
					no_idle = ~no_idle;
				end
				random_item();
			end
		end
		no_idle = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_data <= '0;
		rsp_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_FIT;
		cfg_data <= '0;
		for (int i = 0; i < ARENA_PARAGRAPHS; i++) hdr_mem[i] = '0;
		arena_up = 1'b0;
		fit_mode = FIT_FIRST;
		arena_base = 0;
		arena_limit = ARENA_END_RST;
		fail_count = 0;
		no_idle = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_not_ready();
		test_operations();
		test_fit_modes();
		test_arena_edges();
		test_random_traffic();

		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("[paragraph_arena_allocator] OK");
		end else begin
			$display("[paragraph_arena_allocator] ERROR");
		end
		$finish;
	end

endmodule
